FILE: hw/rtl/udprx_pkg.sv
// Shared types and constants for the UDP receive checksum / port demux block.
// Request and result structs, function and status codes. No dependencies.
package udprx_pkg;

  localparam logic [1:0] FUNC_BIND   = 2'd0;
  localparam logic [1:0] FUNC_UNBIND = 2'd1;
  localparam logic [1:0] FUNC_WORD   = 2'd2;
  localparam logic [1:0] FUNC_SPARE  = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BADARG  = 3'd1;
  localparam logic [2:0] ST_INUSE   = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_SHORT   = 3'd4;
  localparam logic [2:0] ST_TRUNC   = 3'd5;
  localparam logic [2:0] ST_BADSUM  = 3'd6;
  localparam logic [2:0] ST_UNBOUND = 3'd7;

  localparam logic [7:0]  SOCK_RESERVED  = 8'hFF;
  localparam logic [15:0] ONES16         = 16'hFFFF;
  localparam logic [15:0] PROTO_UDP      = 16'd17;
  localparam logic [14:0] WORD_COUNT_MAX = 15'h7FFF;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] port;
    logic [7:0]  sock_id;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] data_word;
    logic        word_last;
    logic [15:0] dgram_len;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  out_sock_id;
    logic [15:0] out_src_port;
    logic [15:0] out_dst_port;
    logic [15:0] body_len;
  } res_t;

  // Command broadcast to every binding cell.
  typedef struct packed {
    logic [15:0] cmp_port;
    logic [7:0]  sock_id;
    logic        unbind_go;
  } cell_cmd_t;

  // Chain signals handed from one cell to the next.
  typedef struct packed {
    logic       free_seen;
    logic       hit_seen;
    logic [7:0] sock_acc;
  } cell_link_t;

endpackage

FILE: hw/rtl/udprx_cell.sv
// One binding slot: holds a port and its socket, compares against the
// broadcast port and passes free/hit/socket info to the next cell. Uses udprx_pkg.
module udprx_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  udprx_pkg::cell_cmd_t  cmd,
  input  logic                  bind_go,
  input  udprx_pkg::cell_link_t link_in,
  output udprx_pkg::cell_link_t link_out
);
  import udprx_pkg::*;

  logic [15:0] port;
  logic [7:0]  sock;
  logic        free;
  logic        hit;

  assign free = (port == 16'd0);
  assign hit  = !free && (port == cmd.cmp_port);

  assign link_out.free_seen = link_in.free_seen | free;
  assign link_out.hit_seen  = link_in.hit_seen | hit;
  assign link_out.sock_acc  = link_in.sock_acc | (sock & {8{hit}});

  always_ff @(posedge clk) begin
    if (rst) begin
      port <= 16'd0;
    end else if (bind_go && free && !link_in.free_seen) begin
      port <= cmd.cmp_port;
    end else if (cmd.unbind_go && hit) begin
      port <= 16'd0;
    end
  end

  // take the socket id on the claiming bind
  always_ff @(posedge clk) begin
    if (bind_go && free && !link_in.free_seen) begin
      sock <= cmd.sock_id;
    end
  end

endmodule

FILE: hw/rtl/udp_rx_checksum_port_demux.sv
// Top level of the UDP receive checksum check and port demultiplexer.
// Instantiates a chain of udprx_cell binding slots; uses udprx_pkg.
//
//   channel | valid     | stall     | payload
//   request | rx_valid  | rx_stall  | rx  (udprx_pkg::req_t)
//   result  | res_valid | res_stall | res (udprx_pkg::res_t)
//
// Bind, unbind and non-final datagram words are handled in the cycle they are accepted.
// A final datagram word also needs a finishing cycle: the accept cycle folds the word into the
// running sum, the next cycle adds the pseudo-header and looks up the port.
// The table compare is one pass along the cell chain per cycle.
// Reset clears the binding ports and the per-datagram state.
// rx_stall is high during the finishing cycle of a final word and while a
// result is held because res_stall is high.
module udp_rx_checksum_port_demux #(
  parameter int BINDING_SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rx_valid,
  output logic              rx_stall,
  input  udprx_pkg::req_t   rx,
  output logic              res_valid,
  input  logic              res_stall,
  output udprx_pkg::res_t   res
);
  import udprx_pkg::*;

  // per-datagram state
  logic [15:0] csum_acc;
  logic [14:0] word_count;
  logic [15:0] claimed_len;
  logic [15:0] hdr_src_port;
  logic [15:0] hdr_dst_port;
  logic        csum_present;
  // final-word capture for the finishing cycle
  logic        fin_pend;
  logic [31:0] fin_sip;
  logic [31:0] fin_dip;
  logic [15:0] fin_rlen;

  logic       accept;
  logic       bind_go;
  cell_cmd_t  cmd;
  cell_link_t link [BINDING_SLOTS+1];

  assign rx_stall = fin_pend | (res_valid & res_stall);
  assign accept   = rx_valid & ~rx_stall;

  // one compare port: header destination while finishing, else request port
  assign cmd.cmp_port  = fin_pend ? hdr_dst_port : rx.port;
  assign cmd.sock_id   = rx.sock_id;
  assign cmd.unbind_go = accept && (rx.func == FUNC_UNBIND) && (rx.port != 16'd0);

  assign link[0] = '0;

  genvar g;
  generate
    for (g = 0; g < BINDING_SLOTS; g++) begin : g_cell
      udprx_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .cmd      (cmd),
        .bind_go  (bind_go),
        .link_in  (link[g]),
        .link_out (link[g+1])
      );
    end
  endgenerate

  logic any_hit, any_free;
  logic [7:0] hit_sock;
  assign any_hit  = link[BINDING_SLOTS].hit_seen;
  assign any_free = link[BINDING_SLOTS].free_seen;
  assign hit_sock = link[BINDING_SLOTS].sock_acc;

  // bind decision
  logic       bind_bad;
  logic [2:0] bind_status;
  assign bind_bad = (rx.port == 16'd0) || (rx.sock_id == SOCK_RESERVED);
  assign bind_go  = accept && (rx.func == FUNC_BIND) && !bind_bad && !any_hit && any_free;

  always_comb begin
    priority if (bind_bad) begin
      bind_status = ST_BADARG;
    end else if (any_hit) begin
      bind_status = ST_INUSE;
    end else if (!any_free) begin
      bind_status = ST_FULL;
    end else begin
      bind_status = ST_OK;
    end
  end

  // word fold: pick the claimed bytes of this word and add end-around
  logic [15:0] cl_new;
  logic [15:0] first_byte;
  logic        sum_full, sum_half;
  logic [15:0] addend;
  logic [16:0] word_sum;
  logic [15:0] acc_next;

  assign cl_new     = (word_count == 15'd2) ? rx.data_word : claimed_len;
  assign first_byte = {word_count, 1'b0};
  assign sum_full   = (word_count < 15'd4) ||
                      (({1'b0, first_byte} + 17'd1) < {1'b0, cl_new});
  assign sum_half   = first_byte < cl_new;

  always_comb begin
    priority if (sum_full) begin
      addend = rx.data_word;
    end else if (sum_half) begin
      addend = {rx.data_word[15:8], 8'h00};
    end else begin
      addend = 16'd0;
    end
  end

  assign word_sum = {1'b0, csum_acc} + {1'b0, addend};
  assign acc_next = word_sum[15:0] + {15'd0, word_sum[16]};

  // finishing cycle: pseudo-header sum, checks, lookup
  logic [18:0] ph_sum;
  logic [16:0] ph_fold;
  logic [15:0] ph_final;
  logic [2:0]  fin_status;

  assign ph_sum = {3'd0, csum_acc} + {3'd0, fin_sip[31:16]} + {3'd0, fin_sip[15:0]}
                + {3'd0, fin_dip[31:16]} + {3'd0, fin_dip[15:0]}
                + {3'd0, PROTO_UDP} + {3'd0, claimed_len};
  assign ph_fold  = {1'b0, ph_sum[15:0]} + {14'd0, ph_sum[18:16]};
  assign ph_final = ph_fold[15:0] + {15'd0, ph_fold[16]};

  always_comb begin
    priority if (fin_rlen < 16'd8 || claimed_len < 16'd8) begin
      fin_status = ST_SHORT;
    end else if (claimed_len > fin_rlen) begin
      fin_status = ST_TRUNC;
    end else if (csum_present && ph_final != ONES16) begin
      fin_status = ST_BADSUM;
    end else if (any_hit) begin
      fin_status = ST_OK;
    end else begin
      fin_status = ST_UNBOUND;
    end
  end

  // per-datagram registers
  always_ff @(posedge clk) begin
    if (rst) begin
      csum_acc     <= 16'd0;
      word_count   <= 15'd0;
      claimed_len  <= 16'd0;
      hdr_src_port <= 16'd0;
      hdr_dst_port <= 16'd0;
      csum_present <= 1'b0;
      fin_pend     <= 1'b0;
    end else if (fin_pend) begin
      // drop all per-datagram state after the result is built
      csum_acc     <= 16'd0;
      word_count   <= 15'd0;
      claimed_len  <= 16'd0;
      hdr_src_port <= 16'd0;
      hdr_dst_port <= 16'd0;
      csum_present <= 1'b0;
      fin_pend     <= 1'b0;
    end else if (accept && rx.func == FUNC_WORD) begin
      csum_acc    <= acc_next;
      claimed_len <= cl_new;
      if (word_count == 15'd0) begin
        hdr_src_port <= rx.data_word;
      end
      if (word_count == 15'd1) begin
        hdr_dst_port <= rx.data_word;
      end
      if (word_count == 15'd3) begin
        csum_present <= (rx.data_word != 16'd0);
      end
      if (word_count != WORD_COUNT_MAX) begin
        word_count <= word_count + 15'd1;
      end
      fin_pend <= rx.word_last;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && rx.func == FUNC_WORD && rx.word_last) begin
      fin_sip  <= rx.src_ip;
      fin_dip  <= rx.dst_ip;
      fin_rlen <= rx.dgram_len;
    end
  end

  // result register: load on bind or on the finishing cycle, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fin_pend) begin
      res_valid <= 1'b1;
    end else if (accept && rx.func == FUNC_BIND) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_pend) begin
      res.status       <= fin_status;
      res.out_sock_id  <= (fin_status == ST_OK) ? hit_sock : 8'd0;
      res.out_src_port <= hdr_src_port;
      res.out_dst_port <= hdr_dst_port;
      res.body_len     <= (fin_status == ST_OK) ? (claimed_len - 16'd8) : 16'd0;
    end else if (accept && rx.func == FUNC_BIND) begin
      res.status       <= bind_status;
      res.out_sock_id  <= 8'd0;
      res.out_src_port <= 16'd0;
      res.out_dst_port <= 16'd0;
      res.body_len     <= 16'd0;
    end
  end

endmodule
